### hdl/slot_and_kv_admission_control_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot and cache admission controller
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLOT_AND_KV_ADMISSION_CONTROL_UNIT_MACROS_SVH
`define SLOT_AND_KV_ADMISSION_CONTROL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SAKAC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("admission control check failed");
// The consequent must hold in the cycle after the antecedent.
`define SAKAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("admission control check failed");
`else
`define SAKAC_ASSERT_SAME(label, ante, cons)
`define SAKAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/sakac_pkg.sv
// ----------------------------------------------------------------------------
// sakac_pkg
// Types and constants shared by the slot and cache admission controller.
// ----------------------------------------------------------------------------
package sakac_pkg;

	localparam int CAP_W  = 21;
	localparam int NEED_W = CAP_W + 1;
	localparam int ACC_W  = 48;
	localparam int SLOT_W = 4;
	localparam int FCNT_W = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 21'd4096;

	typedef enum logic [1:0] {
		ACT_ADMIT  = 2'd0,
		ACT_RETIRE = 2'd1,
		ACT_STEP   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_ADMITTED   = 3'd0,
		ST_NO_SLOT    = 3'd1,
		ST_KV_FULL    = 3'd2,
		ST_NEVER_FITS = 3'd3,
		ST_POLICY     = 3'd4,
		ST_RETIRED    = 3'd5,
		ST_BAD_RETIRE = 3'd6,
		ST_STEPPED    = 3'd7
	} status_t;

	typedef enum logic {
		REG_STATIC_BATCHING = 1'b0,
		REG_KV_CAPACITY     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CAP_W-1:0]  prompt_len;
		logic [CAP_W-1:0]  gen_limit;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] granted_slot;
		logic [CAP_W-1:0]  committed_tokens;
		logic [FCNT_W-1:0] free_slot_count;
		logic [ACC_W-1:0]  total_capacity_steps;
		logic [ACC_W-1:0]  idle_capacity_steps;
	} rsp_t;

	typedef struct packed {
		logic pop;
		logic push;
	} pool_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic lookup_busy;
	} pool_stat_t;

endpackage

### hdl/sakac_slot_pool.sv
// ----------------------------------------------------------------------------
// sakac_slot_pool
// Free-id stack, per-slot busy flags and per-slot token reservations.
// ----------------------------------------------------------------------------
`include "slot_and_kv_admission_control_unit_macros.svh"

module sakac_slot_pool #(
	parameter int SLOTS = 16,
	localparam int IDW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW  = $clog2(SLOTS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sakac_pkg::pool_cmd_t       cmd,
	input  logic [sakac_pkg::CAP_W-1:0] wr_need,
	input  logic [IDW-1:0]             lookup_idx,
	output logic [CW-1:0]              count,
	output logic [IDW-1:0]             pop_id,
	output logic [sakac_pkg::CAP_W-1:0] lookup_res,
	output sakac_pkg::pool_stat_t      stat
);

	logic [IDW-1:0]              stack_q [SLOTS];
	logic [sakac_pkg::CAP_W-1:0] res_q [SLOTS];
	logic [SLOTS-1:0]            busy_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_m1;
	logic [IDW-1:0]              top_id;

	// The top of the stack sits one below the fill count.
	assign count_m1 = count_q - CW'(1);
	assign top_id   = stack_q[count_m1[IDW-1:0]];
	assign pop_id   = (32'(top_id) < 32'(SLOTS)) ? top_id : '0;

	assign count            = count_q;
	assign lookup_res       = res_q[lookup_idx];
	assign stat.empty       = (count_q == '0);
	assign stat.full        = (count_q == CW'(SLOTS));
	assign stat.lookup_busy = busy_q[lookup_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(SLOTS);
			busy_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				stack_q[i] <= IDW'(SLOTS - 1 - i);
			end
		end else if (cmd.pop) begin
			count_q        <= count_m1;
			busy_q[pop_id] <= 1'b1;
		end else if (cmd.push) begin
			stack_q[count_q[IDW-1:0]] <= lookup_idx;
			busy_q[lookup_idx]        <= 1'b0;
			count_q                   <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			res_q[pop_id] <= wr_need;
		end
	end

	`SAKAC_ASSERT_SAME(a_pool_no_pop_and_push, cmd.pop, !cmd.push)
	`SAKAC_ASSERT_SAME(a_pool_pop_not_empty, cmd.pop, !stat.empty)
	`SAKAC_ASSERT_NEXT(a_pool_pop_count, cmd.pop, count_q == $past(count_q) - CW'(1))
	`SAKAC_ASSERT_NEXT(a_pool_push_count, cmd.push, count_q == $past(count_q) + CW'(1))

endmodule

### hdl/slot_and_kv_admission_control_unit.sv
// ----------------------------------------------------------------------------
// slot_and_kv_admission_control_unit
// Hands out sequence slots and reserves shared cache tokens for admitted
// requests; returns one result transaction per admit, retire or step.
// ----------------------------------------------------------------------------
// Usage: requests arrive as req transactions on req_valid/req_ready and each
// one produces a single rsp transaction on rsp_valid/rsp_ready, in order.
// An action code of three is consumed and produces no response.
// A request is captured in an input register, decided by one pass of logic
// (stack pop or push, one reservation lookup, a 23-bit add and compare, the
// 48-bit counter adds) and the response lands in an output register that
// drives rsp_valid. Throughput is one transaction per cycle while rsp_ready
// stays high; each item reads the state left by the one before it through
// the same single pass of logic.
// When the receiver holds rsp_ready low, the response register keeps its
// value, the request in the input register waits, and req_ready drops once
// both registers are occupied; nothing is lost or reordered.
// Reset (arst_n low) empties both registers, fills the free stack with ids
// SLOTS-1 down to 0 (id 0 on top), clears every busy flag, the committed
// total, the round flag and both counters, and sets capacity to 4096 and
// continuous admission. No clearing pass is needed after reset.
// The APB-style register port writes static_batching at address 0 and
// kv_capacity at address 4; it should be written only while the unit is idle.
// ----------------------------------------------------------------------------
`include "slot_and_kv_admission_control_unit_macros.svh"

module slot_and_kv_admission_control_unit #(
	parameter int SLOTS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sakac_pkg::ADDR_W-1:0] paddr,
	input  logic [sakac_pkg::DATA_W-1:0] pwdata,
	output logic [sakac_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  sakac_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output sakac_pkg::rsp_t              rsp
);

	localparam int IDW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int XW  = (IDW > sakac_pkg::SLOT_W) ? IDW : sakac_pkg::SLOT_W;

	// Register file.
	logic                        static_q;
	logic [sakac_pkg::CAP_W-1:0] kv_cap_q;
	logic                        cfg_wr;

	// Pipeline and architectural state.
	sakac_pkg::req_t             req_s1;
	logic                        valid_s1;
	sakac_pkg::rsp_t             rsp_q;
	logic                        rsp_valid_q;
	logic [sakac_pkg::CAP_W-1:0] committed_q;
	logic                        round_open_q;
	logic [sakac_pkg::ACC_W-1:0] total_q;
	logic [sakac_pkg::ACC_W-1:0] idle_q;

	// Decision logic.
	logic                         advance;
	logic                         emit;
	logic [sakac_pkg::NEED_W-1:0] need;
	logic [sakac_pkg::NEED_W:0]   committed_plus_need;
	logic [sakac_pkg::CAP_W-1:0]  idle_amt;
	logic                         never_fits;
	logic                         allowed;
	logic                         kv_full;
	logic                         id_in_range;
	logic [XW-1:0]                slot_x;
	logic                         admit_ok;
	logic                         retire_ok;
	sakac_pkg::status_t           status_d;
	logic [sakac_pkg::SLOT_W-1:0] gslot_d;
	logic [sakac_pkg::CAP_W-1:0]  committed_d;
	logic                         round_open_d;
	logic [sakac_pkg::ACC_W-1:0]  total_d;
	logic [sakac_pkg::ACC_W-1:0]  idle_d;
	logic [CW-1:0]                count_d;
	sakac_pkg::pool_cmd_t         cmd_d;
	sakac_pkg::pool_cmd_t         pool_cmd;

	// Slot pool interface.
	logic [CW-1:0]               pool_count;
	logic [IDW-1:0]              pool_pop_id;
	logic [sakac_pkg::CAP_W-1:0] pool_res;
	sakac_pkg::pool_stat_t       pool_stat;

	// ---------------------------------------------------------------------
	// Register port. Writes complete in the access phase; there are no wait
	// states, so pready is tied high.
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_q <= 1'b0;
			kv_cap_q <= sakac_pkg::CAP_RESET;
		end else if (cfg_wr) begin
			case (sakac_pkg::reg_idx_t'(paddr[2]))
				sakac_pkg::REG_STATIC_BATCHING: static_q <= pwdata[0];
				sakac_pkg::REG_KV_CAPACITY:     kv_cap_q <= pwdata[sakac_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sakac_pkg::reg_idx_t'(paddr[2]))
			sakac_pkg::REG_STATIC_BATCHING: prdata = sakac_pkg::DATA_W'(static_q);
			sakac_pkg::REG_KV_CAPACITY:     prdata = sakac_pkg::DATA_W'(kv_cap_q);
			default:                        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Handshake. The stage-1 transaction moves on when the response register
	// is empty or is being drained this cycle; a fresh request can then be
	// captured in the same cycle, so back-to-back traffic flows at full rate.
	// ---------------------------------------------------------------------
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign emit      = advance && (req_s1.action == sakac_pkg::ACT_ADMIT ||
		req_s1.action == sakac_pkg::ACT_RETIRE || req_s1.action == sakac_pkg::ACT_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// ---------------------------------------------------------------------
	// Slot pool: free-id stack, busy flags and reservations. The retire slot
	// id doubles as the lookup address; an out-of-range id is caught by
	// id_in_range before the lookup result is trusted.
	// ---------------------------------------------------------------------
	assign slot_x      = XW'(req_s1.slot);
	assign id_in_range = (SLOTS >= 16) || (32'(req_s1.slot) < 32'(SLOTS));
	assign pool_cmd    = advance ? cmd_d : '0;

	sakac_slot_pool #(
		.SLOTS(SLOTS)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pool_cmd),
		.wr_need   (need[sakac_pkg::CAP_W-1:0]),
		.lookup_idx(slot_x[IDW-1:0]),
		.count     (pool_count),
		.pop_id    (pool_pop_id),
		.lookup_res(pool_res),
		.stat      (pool_stat)
	);

	// ---------------------------------------------------------------------
	// Decision. Admit checks run in priority order: a request larger than the
	// whole cache, then the static-batching gate, then an empty free stack,
	// then the committed total. Only a successful admit or retire touches
	// the pool and the committed total.
	// ---------------------------------------------------------------------
	assign need                = sakac_pkg::NEED_W'(req_s1.prompt_len) +
		sakac_pkg::NEED_W'(req_s1.gen_limit);
	assign committed_plus_need = (sakac_pkg::NEED_W + 1)'(committed_q) +
		(sakac_pkg::NEED_W + 1)'(need);
	assign never_fits = need > sakac_pkg::NEED_W'(kv_cap_q);
	assign allowed    = !static_q || pool_stat.full || round_open_q;
	assign kv_full    = committed_plus_need > (sakac_pkg::NEED_W + 1)'(kv_cap_q);
	// When capacity was lowered under the committed total, idle time adds zero.
	assign idle_amt   = (kv_cap_q > committed_q) ? (kv_cap_q - committed_q) : '0;

	assign admit_ok  = !never_fits && allowed && !pool_stat.empty && !kv_full;
	assign retire_ok = id_in_range && pool_stat.lookup_busy && !pool_stat.full;

	always_comb begin
		status_d     = sakac_pkg::ST_STEPPED;
		gslot_d      = '0;
		committed_d  = committed_q;
		round_open_d = round_open_q;
		total_d      = total_q;
		idle_d       = idle_q;
		cmd_d        = '0;
		case (req_s1.action)
			sakac_pkg::ACT_ADMIT: begin
				if (never_fits) begin
					status_d = sakac_pkg::ST_NEVER_FITS;
				end else if (!allowed) begin
					status_d = sakac_pkg::ST_POLICY;
				end else if (pool_stat.empty) begin
					status_d = sakac_pkg::ST_NO_SLOT;
				end else if (kv_full) begin
					status_d = sakac_pkg::ST_KV_FULL;
				end else begin
					status_d     = sakac_pkg::ST_ADMITTED;
					gslot_d      = sakac_pkg::SLOT_W'(pool_pop_id);
					committed_d  = committed_plus_need[sakac_pkg::CAP_W-1:0];
					round_open_d = 1'b1;
					cmd_d.pop    = 1'b1;
				end
			end
			sakac_pkg::ACT_RETIRE: begin
				gslot_d = req_s1.slot;
				if (retire_ok) begin
					status_d    = sakac_pkg::ST_RETIRED;
					committed_d = (committed_q >= pool_res) ? (committed_q - pool_res) : '0;
					cmd_d.push  = 1'b1;
				end else begin
					status_d = sakac_pkg::ST_BAD_RETIRE;
				end
			end
			sakac_pkg::ACT_STEP: begin
				status_d     = sakac_pkg::ST_STEPPED;
				total_d      = total_q + sakac_pkg::ACC_W'(kv_cap_q);
				idle_d       = idle_q + sakac_pkg::ACC_W'(idle_amt);
				round_open_d = 1'b0;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (cmd_d.pop) begin
			count_d = pool_count - CW'(1);
		end else if (cmd_d.push) begin
			count_d = pool_count + CW'(1);
		end else begin
			count_d = pool_count;
		end
	end

	// ---------------------------------------------------------------------
	// State update and response register.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q  <= '0;
			round_open_q <= 1'b0;
			total_q      <= '0;
			idle_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				committed_q  <= committed_d;
				round_open_q <= round_open_d;
				total_q      <= total_d;
				idle_q       <= idle_d;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.status               <= status_d;
			rsp_q.granted_slot         <= gslot_d;
			rsp_q.committed_tokens     <= committed_d;
			rsp_q.free_slot_count      <= sakac_pkg::FCNT_W'(count_d);
			rsp_q.total_capacity_steps <= total_d;
			rsp_q.idle_capacity_steps  <= idle_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`SAKAC_ASSERT_NEXT(a_admit_opens_round, advance && req_s1.action == sakac_pkg::ACT_ADMIT && admit_ok, round_open_q)
	`SAKAC_ASSERT_NEXT(a_step_closes_round, advance && req_s1.action == sakac_pkg::ACT_STEP, !round_open_q)
	`SAKAC_ASSERT_NEXT(a_retire_lowers_committed, advance && req_s1.action == sakac_pkg::ACT_RETIRE, committed_q <= $past(committed_q))

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for slot_and_kv_admission_control_unit. A behavioral
// copy of the slot stack, reservations and step counters predicts every
// response, and a checker compares each response field by field.
// ----------------------------------------------------------------------------
module testbench;

	// The block is built with sixteen slots, and the prediction below assumes
	// the same count.
	localparam int SLOTS = 16;

	// Action code three has no meaning. The block consumes it and returns no
	// response.
	localparam logic [1:0] ACTION_UNUSED = 2'd3;

	// Cycles allowed after the last response before the unit counts as idle.
	// The pipeline is two registers deep, so this is comfortably more.
	localparam int SETTLE_CYCLES = 8;

	// Receiver hold-off in the backpressure test, in clock cycles.
	localparam int HOLD_OFF_CYCLES = 80;

	// Clock, reset and all inputs of the block start at known values.
	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [sakac_pkg::ADDR_W-1:0]   paddr     = '0;
	logic [sakac_pkg::DATA_W-1:0]   pwdata    = '0;
	logic [sakac_pkg::DATA_W-1:0]   prdata;
	logic                           pready;
	logic                           req_valid = 1'b0;
	logic                           req_ready;
	sakac_pkg::req_t                req       = '0;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	sakac_pkg::rsp_t                rsp;

	// Shadow state of the block. It is updated when a request transaction is
	// accepted, so it always matches the block after that request.
	logic                           cfg_static;
	logic [sakac_pkg::CAP_W-1:0]    cfg_capacity;
	logic [sakac_pkg::SLOT_W-1:0]   pool_ids [SLOTS];
	int unsigned                    pool_free;
	logic [sakac_pkg::CAP_W-1:0]    slot_reserved [SLOTS];
	bit                             slot_held [SLOTS];
	logic [sakac_pkg::CAP_W-1:0]    reserved_total;
	bit                             round_open;
	logic [sakac_pkg::ACC_W-1:0]    capacity_acc;
	logic [sakac_pkg::ACC_W-1:0]    idle_acc;

	// Responses predicted but not yet received, oldest first.
	sakac_pkg::rsp_t                outcome_queue [$];

	// Traffic shaping. A steady side never inserts idle cycles. The test
	// that wants a long receiver hold-off posts its length here.
	bit                  send_steady   = 1'b0;
	bit                  recv_steady   = 1'b0;
	int unsigned         hold_off_post = 0;

	// Bookkeeping for the summary.
	int unsigned         error_count    = 0;
	int unsigned         requests_sent  = 0;
	int unsigned         responses_seen = 0;
	int unsigned         register_writes = 0;
	int unsigned         status_seen [8];

	slot_and_kv_admission_control_unit #(
		.SLOTS(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// A 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Idle gap length for either side: mostly none or short, now and then a
	// long one.
	function automatic int unsigned pick_gap(input bit steady);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Puts the shadow state into its reset condition: id 0 on top of the
	// free stack, every slot free, nothing committed, counters at zero.
	task automatic reset_shadow();
		cfg_static     = 1'b0;
		cfg_capacity   = sakac_pkg::CAP_RESET;
		pool_free      = SLOTS;
		reserved_total = '0;
		round_open     = 1'b0;
		capacity_acc   = '0;
		idle_acc       = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pool_ids[i]      = sakac_pkg::SLOT_W'(SLOTS - 1 - i);
			slot_held[i]     = 1'b0;
			slot_reserved[i] = '0;
		end
	endtask

	// Applies one request to the shadow state and forms the response that
	// the block must give for it. An unused action code gives none.
	task automatic predict_admission(input sakac_pkg::req_t item, output bit produces,
			output sakac_pkg::rsp_t outcome);
		logic [sakac_pkg::CAP_W:0]    need;
		logic [sakac_pkg::CAP_W+1:0]  demand;
		logic [sakac_pkg::CAP_W-1:0]  released;
		logic [sakac_pkg::CAP_W-1:0]  headroom;
		logic [sakac_pkg::SLOT_W-1:0] id;
		logic [sakac_pkg::SLOT_W-1:0] shown_slot;
		sakac_pkg::status_t           verdict;
		produces   = 1'b1;
		shown_slot = '0;
		verdict    = sakac_pkg::ST_STEPPED;
		case (sakac_pkg::action_t'(item.action))
			sakac_pkg::ACT_ADMIT: begin
				// The checks run in a fixed order: never fits, then the static
				// batching policy, then a free slot, then room in the cache.
				need   = {1'b0, item.prompt_len} + {1'b0, item.gen_limit};
				demand = {2'b00, reserved_total} + {1'b0, need};
				if (need > {1'b0, cfg_capacity}) begin
					verdict = sakac_pkg::ST_NEVER_FITS;
				end else if (cfg_static && pool_free != SLOTS && !round_open) begin
					verdict = sakac_pkg::ST_POLICY;
				end else if (pool_free == 0) begin
					verdict = sakac_pkg::ST_NO_SLOT;
				end else if (demand > {2'b00, cfg_capacity}) begin
					verdict = sakac_pkg::ST_KV_FULL;
				end else begin
					pool_free--;
					id                = pool_ids[pool_free];
					slot_held[id]     = 1'b1;
					slot_reserved[id] = need[sakac_pkg::CAP_W-1:0];
					reserved_total    = reserved_total + need[sakac_pkg::CAP_W-1:0];
					round_open        = 1'b1;
					verdict           = sakac_pkg::ST_ADMITTED;
					shown_slot        = id;
				end
			end
			sakac_pkg::ACT_RETIRE: begin
				shown_slot = item.slot;
				if (!slot_held[item.slot] || pool_free >= SLOTS) begin
					verdict = sakac_pkg::ST_BAD_RETIRE;
				end else begin
					slot_held[item.slot] = 1'b0;
					released             = slot_reserved[item.slot];
					reserved_total       = (reserved_total >= released) ?
						reserved_total - released : '0;
					pool_ids[pool_free]  = item.slot;
					pool_free++;
					verdict              = sakac_pkg::ST_RETIRED;
				end
			end
			sakac_pkg::ACT_STEP: begin
				// Capacity below the committed total adds nothing to idle.
				headroom     = (cfg_capacity > reserved_total) ?
					cfg_capacity - reserved_total : '0;
				capacity_acc = capacity_acc + sakac_pkg::ACC_W'(cfg_capacity);
				idle_acc     = idle_acc + sakac_pkg::ACC_W'(headroom);
				round_open   = 1'b0;
				verdict      = sakac_pkg::ST_STEPPED;
			end
			default: begin
				produces = 1'b0;
			end
		endcase
		outcome.status               = verdict;
		outcome.granted_slot         = shown_slot;
		outcome.committed_tokens     = reserved_total;
		outcome.free_slot_count      = sakac_pkg::FCNT_W'(pool_free);
		outcome.total_capacity_steps = capacity_acc;
		outcome.idle_capacity_steps  = idle_acc;
	endtask

	// Request builders. Fields that an action does not use carry random bits.
	function automatic sakac_pkg::req_t admit_item(input logic [sakac_pkg::CAP_W-1:0] prompt,
			input logic [sakac_pkg::CAP_W-1:0] limit);
		sakac_pkg::req_t item;
		item.action     = sakac_pkg::ACT_ADMIT;
		item.prompt_len = prompt;
		item.gen_limit  = limit;
		item.slot       = sakac_pkg::SLOT_W'($urandom);
		return item;
	endfunction

	function automatic sakac_pkg::req_t retire_item(input logic [sakac_pkg::SLOT_W-1:0] id);
		sakac_pkg::req_t item;
		item.action     = sakac_pkg::ACT_RETIRE;
		item.prompt_len = sakac_pkg::CAP_W'($urandom);
		item.gen_limit  = sakac_pkg::CAP_W'($urandom);
		item.slot       = id;
		return item;
	endfunction

	function automatic sakac_pkg::req_t step_item();
		sakac_pkg::req_t item;
		item.action     = sakac_pkg::ACT_STEP;
		item.prompt_len = sakac_pkg::CAP_W'($urandom);
		item.gen_limit  = sakac_pkg::CAP_W'($urandom);
		item.slot       = sakac_pkg::SLOT_W'($urandom);
		return item;
	endfunction

	// Token counts scaled to the current capacity: mostly small, some near
	// the limit, a few beyond it, and now and then any value of the field.
	function automatic logic [sakac_pkg::CAP_W-1:0] random_tokens();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return sakac_pkg::CAP_W'($urandom_range(0, cfg_capacity / 8));
		end else if (roll < 80) begin
			return sakac_pkg::CAP_W'($urandom_range(0, cfg_capacity / 2));
		end else if (roll < 92) begin
			return sakac_pkg::CAP_W'($urandom_range(0, cfg_capacity));
		end else if (roll < 97) begin
			return sakac_pkg::CAP_W'($urandom_range(0, 1048576));
		end
		return sakac_pkg::CAP_W'($urandom);
	endfunction

	// One random request. Retires mostly name a slot that is in use, so that
	// admissions and releases keep cycling through the stack.
	function automatic sakac_pkg::req_t random_request();
		int unsigned                  roll;
		logic [sakac_pkg::SLOT_W-1:0] held_ids [$];
		sakac_pkg::req_t              item;
		roll = $urandom_range(0, 99);
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_held[i]) begin
				held_ids = {held_ids, sakac_pkg::SLOT_W'(i)};
			end
		end
		if (roll < 45) begin
			item = admit_item(random_tokens(), random_tokens());
		end else if (roll < 80) begin
			if (held_ids.size() != 0 && $urandom_range(0, 99) < 85) begin
				item = retire_item(held_ids[$urandom_range(0, held_ids.size() - 1)]);
			end else begin
				item = retire_item(sakac_pkg::SLOT_W'($urandom));
			end
		end else if (roll < 96) begin
			item = step_item();
		end else begin
			item = step_item();
			item.action = ACTION_UNUSED;
		end
		return item;
	endfunction

	// Offers one request transaction and waits for it to be accepted. When
	// no gap is wanted, valid stays high from the previous request and only
	// the payload changes.
	task automatic send_request(input sakac_pkg::req_t item);
		int unsigned     gap;
		bit              produces;
		sakac_pkg::rsp_t outcome;
		gap = pick_gap(send_steady);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		predict_admission(item, produces, outcome);
		if (produces) begin
			outcome_queue = {outcome_queue, outcome};
		end
		requests_sent++;
	endtask

	// Stops offering requests and waits until every predicted response has
	// been received, then lets the pipeline settle. The unit is idle after
	// this, even if the last request was an unused action.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (outcome_queue.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write: a setup phase, then an access phase that completes
	// at the edge where pready is high, then an idle phase on the port. The
	// shadow copy follows the write.
	task automatic write_register(input sakac_pkg::reg_idx_t index,
			input logic [sakac_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (index)
			sakac_pkg::REG_STATIC_BATCHING: cfg_static = value[0];
			sakac_pkg::REG_KV_CAPACITY:     cfg_capacity = value[sakac_pkg::CAP_W-1:0];
			default:                        ;
		endcase
		register_writes++;
	endtask

	task automatic set_policy(input logic static_mode,
			input logic [sakac_pkg::CAP_W-1:0] capacity);
		wait_for_drain();
		write_register(sakac_pkg::REG_STATIC_BATCHING, sakac_pkg::DATA_W'(static_mode));
		write_register(sakac_pkg::REG_KV_CAPACITY, sakac_pkg::DATA_W'(capacity));
	endtask

	// Compares one received response with the oldest prediction.
	task automatic check_response(input sakac_pkg::rsp_t got);
		sakac_pkg::rsp_t want;
		responses_seen++;
		status_seen[got.status]++;
		if (outcome_queue.size() == 0) begin
			$error("response with no request waiting: status %0d slot %0d",
				got.status, got.granted_slot);
			error_count++;
			return;
		end
		want = outcome_queue[0];
		outcome_queue.delete(0);
		if (got.status !== want.status) begin
			$error("status expected %0d actual %0d", want.status, got.status);
			error_count++;
		end
		if (got.granted_slot !== want.granted_slot) begin
			$error("granted_slot expected %0d actual %0d",
				want.granted_slot, got.granted_slot);
			error_count++;
		end
		if (got.committed_tokens !== want.committed_tokens) begin
			$error("committed_tokens expected %0d actual %0d",
				want.committed_tokens, got.committed_tokens);
			error_count++;
		end
		if (got.free_slot_count !== want.free_slot_count) begin
			$error("free_slot_count expected %0d actual %0d",
				want.free_slot_count, got.free_slot_count);
			error_count++;
		end
		if (got.total_capacity_steps !== want.total_capacity_steps) begin
			$error("total_capacity_steps expected %0d actual %0d",
				want.total_capacity_steps, got.total_capacity_steps);
			error_count++;
		end
		if (got.idle_capacity_steps !== want.idle_capacity_steps) begin
			$error("idle_capacity_steps expected %0d actual %0d",
				want.idle_capacity_steps, got.idle_capacity_steps);
			error_count++;
		end
	endtask

	// Response side. Every edge with valid and ready high moves one
	// transaction, which is checked at once. Ready then idles at random, or
	// for a posted hold-off whose length this process counts down itself.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				check_response(rsp);
			end
			if (hold_off_post != 0) begin
				stall_left    = hold_off_post;
				hold_off_post = 0;
			end
			if (stall_left != 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					stall_left = pick_gap(recv_steady);
				end
			end
		end
	end

	// Directed checks with hand-picked values. At reset the capacity is 4096
	// and admission is continuous; ids come off the stack 0, 1, 2 and a
	// released id goes back on top.
	task automatic test_directed();
		logic [sakac_pkg::CAP_W-1:0] all_ones;
		all_ones = '1;
		// Empty request, a normal one, two that can never fit (the top of
		// the range and every bit set), an exact fit and one token too many.
		send_request(admit_item('0, '0));
		send_request(admit_item(sakac_pkg::CAP_W'(2000), sakac_pkg::CAP_W'(1000)));
		send_request(admit_item(sakac_pkg::CAP_W'(1048576), sakac_pkg::CAP_W'(1048576)));
		send_request(admit_item(all_ones, all_ones));
		send_request(admit_item(sakac_pkg::CAP_W'(1096), '0));
		send_request(admit_item('0, sakac_pkg::CAP_W'(1)));
		// A retire of a free slot, a good retire, and the same one again.
		send_request(retire_item(sakac_pkg::SLOT_W'(15)));
		send_request(retire_item(sakac_pkg::SLOT_W'(1)));
		send_request(retire_item(sakac_pkg::SLOT_W'(1)));
		// The unused action code must vanish without a response.
		send_request('{action: ACTION_UNUSED, prompt_len: all_ones,
			gen_limit: all_ones, slot: '1});
		send_request(step_item());

		// Static batching: the round is closed and slots are in use, so the
		// admit is refused until the batch empties. Admits then open a round
		// that the next step closes again.
		set_policy(1'b1, sakac_pkg::CAP_RESET);
		send_request(admit_item(sakac_pkg::CAP_W'(1), sakac_pkg::CAP_W'(1)));
		send_request(retire_item(sakac_pkg::SLOT_W'(0)));
		send_request(retire_item(sakac_pkg::SLOT_W'(2)));
		send_request(admit_item(sakac_pkg::CAP_W'(5), sakac_pkg::CAP_W'(5)));
		send_request(admit_item(sakac_pkg::CAP_W'(5), sakac_pkg::CAP_W'(5)));
		send_request(step_item());
		send_request(admit_item(sakac_pkg::CAP_W'(5), sakac_pkg::CAP_W'(5)));

		// Capacity lowered to its minimum under the committed total: the
		// step adds no idle capacity and even an empty admit is cache full
		// until both reservations are released.
		set_policy(1'b0, sakac_pkg::CAP_W'(1));
		send_request(step_item());
		send_request(admit_item('0, '0));
		send_request(retire_item(sakac_pkg::SLOT_W'(2)));
		send_request(retire_item(sakac_pkg::SLOT_W'(0)));
		send_request(admit_item(sakac_pkg::CAP_W'(1), '0));
		send_request(admit_item(sakac_pkg::CAP_W'(2), '0));
		send_request(retire_item(sakac_pkg::SLOT_W'(0)));

		// Largest capacity in the range, filled exactly by one request.
		set_policy(1'b0, sakac_pkg::CAP_W'(1048576));
		send_request(admit_item(sakac_pkg::CAP_W'(1048576), '0));
		send_request(admit_item('0, sakac_pkg::CAP_W'(1)));
		send_request(step_item());
		send_request(retire_item(sakac_pkg::SLOT_W'(0)));
	endtask

	// Takes every slot with empty requests, asks for one more, then gives
	// the slots back in random order and retires one too many. Neither side
	// idles here.
	task automatic test_fill_and_drain();
		logic [sakac_pkg::SLOT_W-1:0] held_ids [$];
		logic [sakac_pkg::SLOT_W-1:0] swap;
		int unsigned                  pick;
		set_policy(1'b0, sakac_pkg::CAP_RESET);
		send_steady = 1'b1;
		recv_steady = 1'b1;
		repeat (SLOTS + 1) send_request(admit_item('0, '0));
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_held[i]) begin
				held_ids = {held_ids, sakac_pkg::SLOT_W'(i)};
			end
		end
		for (int i = 0; i < held_ids.size(); i++) begin
			pick           = $urandom_range(i, held_ids.size() - 1);
			swap           = held_ids[i];
			held_ids[i]    = held_ids[pick];
			held_ids[pick] = swap;
		end
		foreach (held_ids[i]) begin
			send_request(retire_item(held_ids[i]));
		end
		send_request(retire_item(sakac_pkg::SLOT_W'($urandom)));
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	// Random traffic under a series of register settings, the extremes of
	// both registers among them. Each change waits for the unit to go idle.
	task automatic test_random_traffic();
		logic                        modes [7];
		logic [sakac_pkg::CAP_W-1:0] capacities [7];
		modes      = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		capacities = '{sakac_pkg::CAP_RESET, sakac_pkg::CAP_RESET, sakac_pkg::CAP_W'(1),
			sakac_pkg::CAP_W'(1048576), sakac_pkg::CAP_W'($urandom_range(1, 1048576)),
			sakac_pkg::CAP_W'($urandom_range(64, 512)), sakac_pkg::CAP_W'(16)};
		for (int phase = 0; phase < 7; phase++) begin
			set_policy(modes[phase], capacities[phase]);
			repeat (95) send_request(random_request());
		end
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering back to back, so the unit fills and drops req_ready. The
	// sender then pauses until every response has come.
	task automatic test_backpressure();
		set_policy(1'b0, sakac_pkg::CAP_RESET);
		send_steady   = 1'b1;
		hold_off_post = HOLD_OFF_CYCLES;
		repeat (30) send_request(random_request());
		send_steady = 1'b0;
		wait_for_drain();
		repeat (20) send_request(random_request());
	endtask

	initial begin
		reset_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_traffic();
		test_backpressure();
		wait_for_drain();

		$display("Run covered %0d requests and %0d responses over %0d register writes.",
			requests_sent, responses_seen, register_writes);
		$display("Outcomes: admitted %0d, no slot %0d, cache full %0d, never fits %0d,",
			status_seen[sakac_pkg::ST_ADMITTED], status_seen[sakac_pkg::ST_NO_SLOT],
			status_seen[sakac_pkg::ST_KV_FULL], status_seen[sakac_pkg::ST_NEVER_FITS]);
		$display("  policy closed %0d, retired %0d, bad retire %0d, stepped %0d.",
			status_seen[sakac_pkg::ST_POLICY], status_seen[sakac_pkg::ST_RETIRED],
			status_seen[sakac_pkg::ST_BAD_RETIRE], status_seen[sakac_pkg::ST_STEPPED]);
		if (error_count == 0) begin
			$display("[slot_and_kv_admission_control_unit] OK");
		end else begin
			$display("[slot_and_kv_admission_control_unit] ERROR");
		end
		$finish;
	end

	// Watchdog: far longer than the slowest correct run can take.
	initial begin
		#800000;
		$display("[slot_and_kv_admission_control_unit] ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/sakac_pkg.sv
hdl/sakac_slot_pool.sv
hdl/slot_and_kv_admission_control_unit.sv
tb/testbench.sv
